>>> rtl/core/cqpw_pkg.sv
// shared types and constants for the byte queue with priority join and withdraw
// no dependencies; used by the channel interfaces and the top level
package cqpw_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_JOIN     = 2'd0,
        CMD_SERVE    = 2'd1,
        CMD_PRIO     = 2'd2,
        CMD_WITHDRAW = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

>>> rtl/core/cqpw_req_if.sv
// request channel: one command beat with its byte
// depends on cqpw_pkg for field widths
interface cqpw_req_if;
    logic                        valid;
    logic                        ready;
    logic [cqpw_pkg::CMD_W-1:0]  command;
    logic [cqpw_pkg::BYTE_W-1:0] item_byte;

    modport source (output valid, output command, output item_byte, input ready);
    modport sink   (input valid, input command, input item_byte, output ready);
endinterface

>>> rtl/core/cqpw_rsp_if.sv
// response channel: status, served byte and occupancy for each command
// depends on cqpw_pkg for field widths
interface cqpw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cqpw_pkg::STATUS_W-1:0] status;
    logic [cqpw_pkg::BYTE_W-1:0]   served_byte;
    logic [cqpw_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output served_byte, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input served_byte, input occupancy,
                    output ready);
endinterface

>>> rtl/core/char_queue_with_priority_and_withdraw.sv
// byte queue with rear join, front serve, front priority join and withdraw by value
// join, serve, priority join and any command on an empty queue: the response is registered and
// valid in the cycle after the beat is accepted; withdraw scans: one shared byte comparator steps
// from the rear toward the front one entry a cycle; the gap closes in the cycle of the match
// throughput: one beat a cycle for those while responses are taken; no new beat during a scan
// reset (rst_n, async, low) empties the queue; entry contents are not cleared
module char_queue_with_priority_and_withdraw (
    input  logic             clk,
    input  logic             rst_n,
    cqpw_req_if.sink         req,
    cqpw_rsp_if.source       rsp
);
    import cqpw_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                  state_reg,    state_next;
    logic [CNT_W-1:0]        cnt_reg,      cnt_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [BYTE_W-1:0]       key_reg,      key_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg,   status_next;
    logic [BYTE_W-1:0]       served_reg,   served_next;
    logic [OCC_W-1:0]        occ_reg,      occ_next;

    logic [BYTE_W-1:0]       entry_reg  [QUEUE_DEPTH];
    logic [BYTE_W-1:0]       entry_next [QUEUE_DEPTH];

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    hit;
    logic                    load;
    cmd_t                    cmd;

    assign cmd   = cmd_t'(req.command);
    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    // shared comparator, one entry per cycle
    assign hit   = (entry_reg[scan_idx_reg] == key_reg);

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.served_byte = served_reg;
    assign rsp.occupancy   = occ_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        scan_idx_next = scan_idx_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        served_next   = served_reg;
        load          = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    served_next = '0;
                    status_next = ST_OK;
                    case (cmd)
                        CMD_JOIN:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                entry_next[cnt_reg[IDX_W-1:0]] = req.item_byte;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_SERVE:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                served_next = entry_reg[0];
                                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                                begin
                                    entry_next[i] = entry_reg[i + 1];
                                end
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        CMD_PRIO:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                for (int i = 1; i < QUEUE_DEPTH; i++)
                                begin
                                    entry_next[i] = entry_reg[i - 1];
                                end
                                entry_next[0] = req.item_byte;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_WITHDRAW:
                        begin
                            if (empty)
                            begin
                                load        = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // start at the rear entry
                                scan_idx_next = IDX_W'(cnt_reg - 1'b1);
                                key_next      = req.item_byte;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                served_next = '0;
                if (hit)
                begin
                    // close the gap: everything behind the match moves one towards the front
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (IDX_W'(i) >= scan_idx_reg)
                        begin
                            entry_next[i] = entry_reg[i + 1];
                        end
                    end
                    cnt_next    = cnt_reg - 1'b1;
                    status_next = ST_OK;
                    load        = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (scan_idx_reg == '0)
                begin
                    status_next = ST_NOT_FOUND;
                    load        = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !rsp.ready) || load;
        occ_next       = load ? OCC_W'(cnt_next) : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            scan_idx_reg  <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            served_reg    <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_idx_reg  <= scan_idx_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            served_reg    <= served_next;
            occ_reg       <= occ_next;
        end
    end

    // entry storage, payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> {1'b0, scan_idx_reg} < cnt_reg)
        else $error("scan index outside occupied entries");

    a_withdraw_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && hit) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("withdraw match did not remove an entry");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> rsp.occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full status with queue not full");

endmodule
